[rtl/i2cepw_pkg.sv]
// shared types, constants and helper functions for the eeprom page write sequencer
package i2cepw_pkg;

  // field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned OFFSET_W = 18;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned TYPE_W   = 4;
  localparam int unsigned PINS_W   = 3;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CIDX_W   = 2;

  // defaults for top level parameters
  localparam int unsigned MAX_COUNT_DEF   = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // control byte bases
  localparam logic [7:0] CTRL_WRITE = 8'hA0;
  localparam logic [7:0] CTRL_READ  = 8'hA1;

  // chip type boundaries
  localparam logic [TYPE_W-1:0] TYPE_NO_SEL_MAX = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_BANKED_MAX = 4'd4;
  localparam logic [TYPE_W-1:0] TYPE_TWO_ADDR   = 4'd5;
  localparam logic [TYPE_W-1:0] TYPE_BIG        = 4'd9;
  localparam logic [TYPE_W-1:0] TYPE_VALID_MAX  = 4'd9;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_CHIP_TYPE   = 2'd0,
    REG_SELECT_PINS = 2'd1,
    REG_IS_1024     = 2'd2
  } reg_idx_e;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_SEEK_ABS = 2'd0,
    CMD_SEEK_REL = 2'd1,
    CMD_READ     = 2'd2,
    CMD_WRITE    = 2'd3
  } cmd_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_SEEK  = 2'd2
  } kind_e;

  // sequencer states
  typedef enum logic {
    BS_IDLE,
    BS_WRITE
  } back_state_e;

  // configuration registers
  typedef struct packed {
    logic [TYPE_W-1:0] chip_type;
    logic [PINS_W-1:0] select_pins;
    logic              is_1024;
  } cfg_t;

  // classified request as it sits in the queue
  typedef struct packed {
    cmd_e                        cmd;
    logic signed [OFFSET_W-1:0]  offset;
    logic [COUNT_W-1:0]          count;
  } item_t;

  // one result transaction
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         control_byte;
    logic [7:0]         read_control_byte;
    logic [7:0]         addr_high;
    logic [7:0]         addr_low;
    logic [1:0]         addr_bytes;
    logic [COUNT_W-1:0] length;
    logic [POS_W-1:0]   new_position;
    logic               last;
  } res_t;

  // page size minus one for a chip type
  function automatic logic [7:0] page_mask(input logic [TYPE_W-1:0] chip_type);
    logic [7:0] m;
    if (chip_type <= 4'd1)      m = 8'd7;
    else if (chip_type <= 4'd4) m = 8'd15;
    else if (chip_type <= 4'd6) m = 8'd31;
    else if (chip_type <= 4'd8) m = 8'd63;
    else                        m = 8'd127;
    return m;
  endfunction

  // device select field for a position
  function automatic logic [2:0] dev_select(input cfg_t cfg, input logic [POS_W-1:0] pos);
    logic [2:0] s;
    if (cfg.chip_type <= TYPE_NO_SEL_MAX)      s = 3'd0;
    else if (cfg.chip_type <= TYPE_BANKED_MAX) s = pos[10:8];
    else if (cfg.chip_type == TYPE_BIG && cfg.is_1024) s = {pos[16], cfg.select_pins[1:0]};
    else                                       s = cfg.select_pins;
    return s;
  endfunction

endpackage

[rtl/i2c_eeprom_page_write_sequencer_unit.sv]
// top level of the 24xx eeprom page write sequencer
// Tracks the byte position of a 24xx-family serial EEPROM and turns seek,
// read and write requests into bus transaction descriptors. A seek or a read
// gives one result; a write gives one segment for each page it touches (one
// segment for a zero-length write), one per cycle while the output accepts
// them. The first result of a request is registered in the back end's output
// register once the request has passed through the queue. A two-entry queue
// lets requests be taken while the back end works or waits on the output.
// Reads and writes with an unsupported chip type are taken and produce no
// result. Configuration is written through a plain write port while the unit
// is idle; the user is bound to this, as the unit itself does not enforce it.
module i2c_eeprom_page_write_sequencer_unit #(
  parameter int unsigned MAX_COUNT   = i2cepw_pkg::MAX_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH = i2cepw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [i2cepw_pkg::CIDX_W-1:0]          cfg_idx_i,
  input  logic [i2cepw_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [i2cepw_pkg::CMD_W-1:0]           command_i,
  input  logic signed [i2cepw_pkg::OFFSET_W-1:0] offset_i,
  input  logic [i2cepw_pkg::COUNT_W-1:0]         count_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [1:0]                             kind_o,
  output logic [7:0]                             control_byte_o,
  output logic [7:0]                             read_control_byte_o,
  output logic [7:0]                             addr_high_o,
  output logic [7:0]                             addr_low_o,
  output logic [1:0]                             addr_bytes_o,
  output logic [i2cepw_pkg::COUNT_W-1:0]         length_o,
  output logic [i2cepw_pkg::POS_W-1:0]           new_position_o,
  output logic                                   last_o
);
  import i2cepw_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  push, push_ready, q_valid, q_pop;
  item_t push_item, q_item;
  res_t  res;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CHIP_TYPE:   cfg_d.chip_type   = cfg_wdata_i[TYPE_W-1:0];
        REG_SELECT_PINS: cfg_d.select_pins = cfg_wdata_i[PINS_W-1:0];
        REG_IS_1024:     cfg_d.is_1024     = cfg_wdata_i[0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  i2cepw_front #(
    .MAX_COUNT(MAX_COUNT)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .offset_i    (offset_i),
    .count_i     (count_i),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .push_ready_i(push_ready),
    .item_o      (push_item)
  );

  i2cepw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .item_i      (push_item),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .item_o      (q_item)
  );

  i2cepw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  // result fields
  assign kind_o              = res.kind;
  assign control_byte_o      = res.control_byte;
  assign read_control_byte_o = res.read_control_byte;
  assign addr_high_o         = res.addr_high;
  assign addr_low_o          = res.addr_low;
  assign addr_bytes_o        = res.addr_bytes;
  assign length_o            = res.length;
  assign new_position_o      = res.new_position;
  assign last_o              = res.last;

endmodule

[rtl/i2cepw_front.sv]
// request front end: count saturation, classification and drop of unsupported requests
module i2cepw_front #(
  parameter int unsigned MAX_COUNT = 256
) (
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [i2cepw_pkg::CMD_W-1:0]         command_i,
  input  logic signed [i2cepw_pkg::OFFSET_W-1:0] offset_i,
  input  logic [i2cepw_pkg::COUNT_W-1:0]       count_i,
  input  i2cepw_pkg::cfg_t                     cfg_i,
  output logic                                 push_o,
  input  logic                                 push_ready_i,
  output i2cepw_pkg::item_t                    item_o
);
  import i2cepw_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCnt = COUNT_W'(MAX_COUNT);

  cmd_e cmd;
  logic is_xfer;
  logic drop;

  // classify and saturate
  always_comb begin
    cmd          = cmd_e'(command_i);
    is_xfer      = (cmd == CMD_READ) || (cmd == CMD_WRITE);
    drop         = is_xfer && (cfg_i.chip_type > TYPE_VALID_MAX);
    item_o.cmd    = cmd;
    item_o.offset = offset_i;
    item_o.count  = (count_i > MaxCnt) ? MaxCnt : count_i;
  end

  // unsupported reads and writes are taken and discarded
  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i && !drop;

endmodule

[rtl/i2cepw_queue.sv]
// small request queue between front end and sequencer
module i2cepw_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  i2cepw_pkg::item_t item_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output i2cepw_pkg::item_t item_o
);
  import i2cepw_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/i2cepw_back.sv]
// sequencer: position register, page split and result output register
module i2cepw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  i2cepw_pkg::cfg_t  cfg_i,
  input  logic              q_valid_i,
  input  i2cepw_pkg::item_t q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2cepw_pkg::res_t  res_o
);
  import i2cepw_pkg::*;

  back_state_e        state_q, state_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;

  logic               load_ok, load;
  logic [COUNT_W-1:0] cur_rem, room, seg, rem_left;
  logic [7:0]         mask;
  logic [POS_W-1:0]   np_wr, np_rd, np_seek;
  logic [POS_W+1:0]   rel_sum;
  logic [2:0]         sel;
  logic               two;
  res_t               seg_res, rd_res, seek_res;

  // segment, read and seek results from the current position
  always_comb begin
    cur_rem  = (state_q == BS_WRITE) ? rem_q : q_item_i.count;
    mask     = page_mask(cfg_i.chip_type);
    room     = {1'b0, mask} + 9'd1 - {1'b0, pos_q[7:0] & mask};
    seg      = (cur_rem < room) ? cur_rem : room;
    rem_left = cur_rem - seg;
    np_wr    = pos_q + {{(POS_W - COUNT_W){1'b0}}, seg};
    np_rd    = pos_q + {{(POS_W - COUNT_W){1'b0}}, q_item_i.count};
    sel      = dev_select(cfg_i, pos_q);
    two      = (cfg_i.chip_type >= TYPE_TWO_ADDR);

    rel_sum  = {2'b00, pos_q} + {q_item_i.offset[OFFSET_W-1], q_item_i.offset};
    if (q_item_i.cmd == CMD_SEEK_ABS) begin
      np_seek = q_item_i.offset[OFFSET_W-1] ? '0 : q_item_i.offset[POS_W-1:0];
    end else begin
      np_seek = rel_sum[POS_W+1] ? '0 : rel_sum[POS_W-1:0];
    end

    seg_res.kind              = KIND_WRITE;
    seg_res.control_byte      = CTRL_WRITE | {4'b0000, sel, 1'b0};
    seg_res.read_control_byte = 8'd0;
    seg_res.addr_high         = two ? pos_q[15:8] : 8'd0;
    seg_res.addr_low          = pos_q[7:0];
    seg_res.addr_bytes        = two ? 2'd2 : 2'd1;
    seg_res.length            = seg;
    seg_res.new_position      = np_wr;
    seg_res.last              = (rem_left == '0);

    rd_res                    = seg_res;
    rd_res.kind               = KIND_READ;
    rd_res.read_control_byte  = CTRL_READ | {4'b0000, sel, 1'b0};
    rd_res.length             = q_item_i.count;
    rd_res.new_position       = np_rd;
    rd_res.last               = 1'b1;

    seek_res                  = '0;
    seek_res.kind             = KIND_SEEK;
    seek_res.new_position     = np_seek;
    seek_res.last             = 1'b1;
  end

  // next state and output register load
  always_comb begin
    load_ok = !out_valid_q || out_ready_i;
    load    = 1'b0;
    q_pop_o = 1'b0;
    state_d = state_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    res_d   = res_q;
    case (state_q)
      BS_IDLE: begin
        if (load_ok && q_valid_i) begin
          q_pop_o = 1'b1;
          load    = 1'b1;
          case (q_item_i.cmd)
            CMD_SEEK_ABS, CMD_SEEK_REL: begin
              res_d = seek_res;
              pos_d = np_seek;
            end
            CMD_READ: begin
              res_d = rd_res;
              pos_d = np_rd;
            end
            CMD_WRITE: begin
              res_d = seg_res;
              pos_d = np_wr;
              rem_d = rem_left;
              if (rem_left != '0) begin
                state_d = BS_WRITE;
              end
            end
            default: begin
              res_d = seek_res;
            end
          endcase
        end
      end
      BS_WRITE: begin
        if (load_ok) begin
          load  = 1'b1;
          res_d = seg_res;
          pos_d = np_wr;
          rem_d = rem_left;
          if (rem_left == '0) begin
            state_d = BS_IDLE;
          end
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      pos_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
